// ===== rtl/hash_table_quadratic_probe_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Hash table quadratic probe unit: assertion macros
// Shared assertion forms for the hash table block.
// ----------------------------------------------------------------------------
`ifndef HASH_TABLE_QUADRATIC_PROBE_UNIT_DEFINES_SVH
`define HASH_TABLE_QUADRATIC_PROBE_UNIT_DEFINES_SVH

// same-cycle implication
`define HQP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define HQP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/hqp_pkg.sv =====
// ----------------------------------------------------------------------------
// Hash table quadratic probe package
// Widths, codes, row layout and handshake structs shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none
package hqp_pkg;
    localparam int DEPTH = 1024;
    localparam int AW    = 10;
    localparam int KW    = 32;
    localparam int DW    = 32;
    localparam int CW    = 11;
    localparam int PCW   = 11;
    localparam int ROW_W = 1 + PCW + DW + KW;
    localparam int MCW   = $clog2(KW);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_READ   = 2'd2,
        OP_WRITE  = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_WHOME,
        S_DONE
    } t_state;

    typedef struct packed {
        logic           valid;
        logic [PCW-1:0] pc;
        logic [DW-1:0]  data;
        logic [KW-1:0]  key;
    } t_row;

    typedef struct packed {
        logic          start;
        logic [KW-1:0] dividend;
        logic [CW-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic          busy;
        logic [CW-1:0] rem;
    } t_mod_rsp;
endpackage
`default_nettype wire

// ===== rtl/hqp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module hqp_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== rtl/hqp_mod.sv =====
// ----------------------------------------------------------------------------
// Hash table modulo unit
// Restoring remainder of a key magnitude by the table size, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module hqp_mod
    import hqp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mod_req i_req,
    output t_mod_rsp      o_rsp
);
    logic          r_busy;
    logic [MCW-1:0] r_cnt;
    logic [KW-1:0] r_dvd;
    logic [CW-1:0] r_rem;
    logic [CW-1:0] r_div;
    logic [CW:0]   n_trial;

    always_comb begin
        n_trial = {r_rem, r_dvd[KW-1]};
        if (n_trial >= {1'b0, r_div}) begin
            n_trial = n_trial - {1'b0, r_div};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == MCW'(KW - 1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= '0;
            r_dvd <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt + MCW'(1);
            r_dvd <= {r_dvd[KW-2:0], 1'b0};
            r_rem <= n_trial[CW-1:0];
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.rem  = r_rem;
endmodule
`default_nettype wire

// ===== rtl/hash_table_quadratic_probe_unit.sv =====
// ----------------------------------------------------------------------------
// Hash table quadratic probe unit
// Open-addressed table in one row memory, probed at (|key| + i*i) mod size.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 1024-row memory to zero, one row a cycle,
// and stalls input until the sweep ends. Insert and lookup first take the
// bit-serial remainder of the key magnitude by the table size (32 shift
// steps, then the remainder is handed over), then a memory read and its check
// for each slot probed, then load the output register; an insert whose probe
// count beyond its home slot exceeds the count stored there also writes the
// new count into the home row. Read slot and write slot take a memory read,
// its check and the output load, or the output load alone when the slot index
// lies outside the table; an insert into a full table also goes straight to
// the output load. One item is in work at a time: the next beat can be accepted
// in the same cycle as the result appears, and a result still held by
// output stall keeps the following one waiting in its last step.
`default_nettype none
`include "hash_table_quadratic_probe_unit_defines.svh"
module hash_table_quadratic_probe_unit
    import hqp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CW-1:0]        i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_opcode,
    input  wire logic signed [KW-1:0] i_key,
    input  wire logic [AW-1:0]        i_slot_index,
    input  wire logic [DW-1:0]        i_data_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [1:0]                o_status,
    output logic [AW-1:0]             o_slot,
    output logic signed [KW-1:0]      o_key_out,
    output logic [DW-1:0]             o_data_out,
    output logic                      o_slot_used,
    output logic [CW-1:0]             o_fill_count,
    output logic                      o_over_threshold
);
    t_state        r_state, n_state;
    logic [CW-1:0] r_tsz;
    logic [CW-1:0] r_occ, n_occ;
    t_op           r_op, n_op;
    logic [KW-1:0] r_key, n_key;
    logic [DW-1:0] r_din, n_din;
    logic [AW-1:0] r_i, n_i;
    logic [CW-1:0] r_base, n_base;
    logic [CW-1:0] r_sq, n_sq;
    logic [CW-1:0] r_d, n_d;
    logic [PCW-1:0] r_left, n_left;
    t_row          r_home, n_home;
    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_clr, n_clr;
    logic [1:0]    r_p_status, n_p_status;
    logic [AW-1:0] r_p_slot, n_p_slot;
    logic [KW-1:0] r_p_key, n_p_key;
    logic [DW-1:0] r_p_data, n_p_data;
    logic          r_p_used, n_p_used;
    logic          r_o_valid, n_o_valid;
    logic [1:0]    r_o_status, n_o_status;
    logic [AW-1:0] r_o_slot, n_o_slot;
    logic [KW-1:0] r_o_key, n_o_key;
    logic [DW-1:0] r_o_data, n_o_data;
    logic          r_o_used, n_o_used;
    logic [CW-1:0] r_o_fill, n_o_fill;
    logic          r_o_over, n_o_over;

    logic [CW-1:0] eff_s;
    logic [CW:0]   pos_sum;
    logic [AW-1:0] pos;
    logic [CW:0]   sq_sum, d_sum;
    logic [KW-1:0] mag;
    logic          accept;
    logic [PCW-1:0] left_now;
    logic          over;
    t_row          row, wrow;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [ROW_W-1:0] rdata;
    t_mod_req      mreq;
    t_mod_rsp      mrsp;

    hqp_ram #(.W(ROW_W), .D(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wrow),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    hqp_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_rsp   (mrsp)
    );

    always_comb begin
        if (r_tsz == '0) begin
            eff_s = CW'(1);
        end else if (r_tsz > CW'(DEPTH)) begin
            eff_s = CW'(DEPTH);
        end else begin
            eff_s = r_tsz;
        end
        pos_sum = {1'b0, r_base} + {1'b0, r_sq};
        if (pos_sum >= {1'b0, eff_s}) begin
            pos_sum = pos_sum - {1'b0, eff_s};
        end
        pos = pos_sum[AW-1:0];
        sq_sum = {1'b0, r_sq} + {1'b0, r_d};
        if (sq_sum >= {1'b0, eff_s}) begin
            sq_sum = sq_sum - {1'b0, eff_s};
        end
        d_sum = {1'b0, r_d} + (CW+1)'(2);
        if (d_sum >= {1'b0, eff_s}) begin
            d_sum = d_sum - {1'b0, eff_s};
        end
        if (eff_s == CW'(1)) begin
            d_sum = '0;
        end
        mag = i_key[KW-1] ? (~i_key + KW'(1)) : i_key;
        over = ((CW+4)'(r_occ) * (CW+4)'(10)) > ((CW+4)'(eff_s) * (CW+4)'(7));
    end

    assign accept = i_in_valid && !o_in_stall;
    assign row    = t_row'(rdata);
    assign left_now = (r_i == '0) ? row.pc : r_left;

    always_comb begin
        n_state    = r_state;
        n_occ      = r_occ;
        n_op       = r_op;
        n_key      = r_key;
        n_din      = r_din;
        n_i        = r_i;
        n_base     = r_base;
        n_sq       = r_sq;
        n_d        = r_d;
        n_left     = r_left;
        n_home     = r_home;
        n_addr     = r_addr;
        n_clr      = r_clr;
        n_p_status = r_p_status;
        n_p_slot   = r_p_slot;
        n_p_key    = r_p_key;
        n_p_data   = r_p_data;
        n_p_used   = r_p_used;
        n_o_valid  = r_o_valid;
        n_o_status = r_o_status;
        n_o_slot   = r_o_slot;
        n_o_key    = r_o_key;
        n_o_data   = r_o_data;
        n_o_used   = r_o_used;
        n_o_fill   = r_o_fill;
        n_o_over   = r_o_over;
        mreq.start    = 1'b0;
        mreq.dividend = mag;
        mreq.divisor  = eff_s;
        we    = 1'b0;
        waddr = r_addr;
        wrow  = row;
        raddr = pos;

        if (r_o_valid && !i_out_stall) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
                wrow  = '0;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_op       = t_op'(i_opcode);
                    n_key      = i_key;
                    n_din      = i_data_in;
                    n_i        = '0;
                    n_sq       = '0;
                    n_d        = (eff_s == CW'(1)) ? '0 : CW'(1);
                    n_p_status = ST_MISS;
                    n_p_slot   = '0;
                    n_p_key    = '0;
                    n_p_data   = '0;
                    n_p_used   = 1'b0;
                    unique case (t_op'(i_opcode))
                        OP_INSERT: begin
                            if (r_occ >= eff_s) begin
                                n_p_status = ST_FULL;
                                n_state    = S_DONE;
                            end else begin
                                mreq.start = 1'b1;
                                n_state    = S_HASH;
                            end
                        end
                        OP_LOOKUP: begin
                            mreq.start = 1'b1;
                            n_state    = S_HASH;
                        end
                        OP_READ, OP_WRITE: begin
                            if ({1'b0, i_slot_index} >= eff_s) begin
                                n_state = S_DONE;
                            end else begin
                                n_base  = CW'(i_slot_index);
                                n_state = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_HASH: begin
                if (!mrsp.busy) begin
                    n_base  = mrsp.rem;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_addr  = pos;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = S_DONE;
                unique case (r_op)
                    OP_INSERT: begin
                        if (r_i == '0) begin
                            n_home = row;
                        end
                        if (!row.valid) begin
                            we         = 1'b1;
                            wrow.valid = 1'b1;
                            wrow.data  = r_din;
                            wrow.key   = r_key;
                            n_occ      = r_occ + CW'(1);
                            n_p_status = ST_OK;
                            n_p_slot   = r_addr;
                            n_p_key    = r_key;
                            n_p_data   = r_din;
                            n_p_used   = 1'b1;
                            if (r_i != '0 && PCW'(r_i) > r_home.pc) begin
                                n_state = S_WHOME;
                            end
                        end else if ({1'b0, r_i} == eff_s - CW'(1)) begin
                            n_p_status = ST_FULL;
                        end else begin
                            n_i     = r_i + AW'(1);
                            n_sq    = sq_sum[CW-1:0];
                            n_d     = d_sum[CW-1:0];
                            n_state = S_READ;
                        end
                    end
                    OP_LOOKUP: begin
                        if (row.valid && row.key == r_key) begin
                            n_p_status = ST_OK;
                            n_p_slot   = r_addr;
                            n_p_key    = r_key;
                            n_p_data   = row.data;
                            n_p_used   = 1'b1;
                        end else if (row.valid && left_now != '0) begin
                            n_left  = left_now - PCW'(1);
                            n_i     = r_i + AW'(1);
                            n_sq    = sq_sum[CW-1:0];
                            n_d     = d_sum[CW-1:0];
                            n_state = S_READ;
                        end
                    end
                    OP_READ, OP_WRITE: begin
                        n_p_status = ST_OK;
                        n_p_slot   = r_addr;
                        n_p_key    = row.key;
                        n_p_data   = row.data;
                        n_p_used   = row.valid;
                        if (r_op == OP_WRITE) begin
                            we        = 1'b1;
                            wrow.data = r_din;
                            n_p_data  = r_din;
                        end
                    end
                endcase
            end
            S_WHOME: begin
                we      = 1'b1;
                waddr   = r_base[AW-1:0];
                wrow    = r_home;
                wrow.pc = PCW'(r_i);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_o_valid || !i_out_stall) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_p_status;
                    n_o_slot   = r_p_slot;
                    n_o_key    = r_p_key;
                    n_o_data   = r_p_data;
                    n_o_used   = r_p_used;
                    n_o_fill   = r_occ;
                    n_o_over   = over;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_occ     <= '0;
            r_tsz     <= CW'(DEPTH);
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_occ     <= n_occ;
            r_o_valid <= n_o_valid;
            if (i_cfg_valid) begin
                r_tsz <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_din      <= n_din;
        r_i        <= n_i;
        r_base     <= n_base;
        r_sq       <= n_sq;
        r_d        <= n_d;
        r_left     <= n_left;
        r_home     <= n_home;
        r_addr     <= n_addr;
        r_p_status <= n_p_status;
        r_p_slot   <= n_p_slot;
        r_p_key    <= n_p_key;
        r_p_data   <= n_p_data;
        r_p_used   <= n_p_used;
        r_o_status <= n_o_status;
        r_o_slot   <= n_o_slot;
        r_o_key    <= n_o_key;
        r_o_data   <= n_o_data;
        r_o_used   <= n_o_used;
        r_o_fill   <= n_o_fill;
        r_o_over   <= n_o_over;
    end

    assign o_cfg_ready      = 1'b1;
    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_o_valid;
    assign o_status         = r_o_status;
    assign o_slot           = r_o_slot;
    assign o_key_out        = r_o_key;
    assign o_data_out       = r_o_data;
    assign o_slot_used      = r_o_used;
    assign o_fill_count     = r_o_fill;
    assign o_over_threshold = r_o_over;

    `HQP_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, r_state != S_IDLE)
    `HQP_ASSERT_IMPL(a_status_code, i_clk, i_rst_n, o_out_valid, o_status <= ST_FULL)
    `HQP_ASSERT_IMPL(a_fail_empty, i_clk, i_rst_n, o_out_valid && o_status != ST_OK, !o_slot_used && o_slot == '0)
    `HQP_ASSERT_IMPL(a_fill_bound, i_clk, i_rst_n, 1'b1, r_occ <= CW'(DEPTH))
endmodule
`default_nettype wire

// ===== tb/hash_table_quadratic_probe_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Hash table quadratic probe unit testbench
// Drives insert, lookup, read slot and write slot beats through table size
// settings from 0 to 2047, predicts each result from a local table
// model and compares every result field with the oldest expected result.
// ----------------------------------------------------------------------------
`default_nettype none
module hash_table_quadratic_probe_unit_tb;
    import hqp_pkg::*;

    typedef struct {
        logic [1:0]    status;
        logic [AW-1:0] slot;
        logic [KW-1:0] key;
        logic [DW-1:0] data;
        logic          used;
        logic [CW-1:0] fill;
        logic          over;
    } t_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CW-1:0]        i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [1:0]           i_opcode = '0;
    logic signed [KW-1:0] i_key = '0;
    logic [AW-1:0]        i_slot_index = '0;
    logic [DW-1:0]        i_data_in = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [1:0]           o_status;
    logic [AW-1:0]        o_slot;
    logic signed [KW-1:0] o_key_out;
    logic [DW-1:0]        o_data_out;
    logic                 o_slot_used;
    logic [CW-1:0]        o_fill_count;
    logic                 o_over_threshold;

    hash_table_quadratic_probe_unit u_top (.*);

    always #10 i_clk = ~i_clk;

    logic [KW-1:0] tbl_key [DEPTH];
    logic          tbl_used [DEPTH];
    logic [PCW-1:0] tbl_probes [DEPTH];
    logic [DW-1:0] tbl_data [DEPTH];
    int unsigned   tbl_fill;
    int unsigned   tbl_size;
    t_result       pending_results[$];
    int            error_count = 0;
    int            result_count = 0;
    int            beat_count = 0;
    bit            idle_out = 1'b1;
    int unsigned   out_wait = 0;

    function automatic int unsigned eff_size();
        if (tbl_size == 0) return 1;
        if (tbl_size > DEPTH) return DEPTH;
        return tbl_size;
    endfunction

    function automatic t_result make_result(logic [1:0] st, int unsigned slot,
                                            logic [KW-1:0] k, logic [DW-1:0] d,
                                            logic used);
        t_result r;
        r.status = st;
        r.slot = slot[AW-1:0];
        r.key = k;
        r.data = d;
        r.used = used;
        r.fill = tbl_fill[CW-1:0];
        r.over = (tbl_fill * 10) > (eff_size() * 7);
        return r;
    endfunction

    function automatic t_result predict_table_op(t_op op, logic [KW-1:0] k,
                                                 logic [AW-1:0] idx,
                                                 logic [DW-1:0] d);
        int unsigned s;
        longint unsigned mag;
        int unsigned home;
        int unsigned p;
        int unsigned i;
        int unsigned left;
        s = eff_size();
        mag = {32'h0, k};
        if (k[KW-1]) mag = 64'h1_0000_0000 - {32'h0, k};
        home = 32'(mag % s);
        case (op)
            OP_INSERT: begin
                if (tbl_fill >= s) return make_result(ST_FULL, 0, '0, '0, 1'b0);
                for (i = 0; i < s; i++) begin
                    p = 32'((home + (longint'(i) * i) % s) % s);
                    if (!tbl_used[p]) begin
                        tbl_key[p] = k;
                        tbl_used[p] = 1'b1;
                        tbl_data[p] = d;
                        if (i > tbl_probes[home]) tbl_probes[home] = PCW'(i);
                        tbl_fill++;
                        return make_result(ST_OK, p, k, d, 1'b1);
                    end
                end
                return make_result(ST_FULL, 0, '0, '0, 1'b0);
            end
            OP_LOOKUP: begin
                left = tbl_probes[home];
                i = 0;
                p = home;
                while (tbl_used[p] && tbl_key[p] != k && left > 0) begin
                    i++;
                    left--;
                    p = 32'((home + (longint'(i) * i) % s) % s);
                end
                if (tbl_used[p] && tbl_key[p] == k)
                    return make_result(ST_OK, p, k, tbl_data[p], 1'b1);
                return make_result(ST_MISS, 0, '0, '0, 1'b0);
            end
            default: begin
                if (idx >= s) return make_result(ST_MISS, 0, '0, '0, 1'b0);
                if (op == OP_WRITE) tbl_data[idx] = d;
                return make_result(ST_OK, idx, tbl_key[idx], tbl_data[idx],
                                   tbl_used[idx]);
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("result %0d: %s got %0h expected %0h", result_count, what, got, want);
        error_count++;
    endtask

    task automatic idle_cycles(int n);
        repeat (n) @(negedge i_clk);
    endtask

    task automatic send_beat(t_op op, logic [KW-1:0] k, logic [AW-1:0] idx,
                             logic [DW-1:0] d, bit gaps = 1'b1);
        int unsigned gap;
        gap = gaps ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            idle_cycles(gap);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_key <= k;
        i_slot_index <= idx;
        i_data_in <= d;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(predict_table_op(op, k, idx, d));
        beat_count++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        idle_cycles(8);
    endtask

    task automatic set_table_size(logic [CW-1:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tbl_size = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= (out_wait != 0);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            result_count++;
            out_wait = idle_out ? 0 : $urandom_range(0, 15);
            if (pending_results.size() == 0) begin
                $display("result %0d: no result expected", result_count);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                if (o_slot !== want.slot) report_mismatch("slot", o_slot, want.slot);
                if (o_key_out !== want.key) report_mismatch("key_out", o_key_out, want.key);
                if (o_data_out !== want.data) report_mismatch("data_out", o_data_out, want.data);
                if (o_slot_used !== want.used) report_mismatch("slot_used", o_slot_used, want.used);
                if (o_fill_count !== want.fill)
                    report_mismatch("fill_count", o_fill_count, want.fill);
                if (o_over_threshold !== want.over)
                    report_mismatch("over_threshold", o_over_threshold, want.over);
            end
        end else if (i_rst_n && o_out_valid && i_out_stall && out_wait != 0) begin
            out_wait--;
        end
    end

    function automatic logic [KW-1:0] random_key();
        logic [KW-1:0] k;
        k = $urandom();
        if (k == 32'h8000_0000) k = 32'h7FFF_FFFF;
        return k;
    endfunction

    task automatic test_small_table_edges();
        set_table_size(11'd8);
        send_beat(OP_LOOKUP, 32'sd5, '0, '0);
        send_beat(OP_INSERT, 32'h7FFF_FFFF, '0, 32'hFFFF_FFFF);
        send_beat(OP_INSERT, 32'h8000_0001, '0, 32'h0);
        send_beat(OP_INSERT, 32'sd0, '0, 32'hA5A5_5A5A);
        send_beat(OP_INSERT, 32'sd8, '0, 32'h1234_5678);
        send_beat(OP_INSERT, 32'sd8, '0, 32'h5A5A_A5A5);
        send_beat(OP_INSERT, -32'sd16, '0, 32'h0F0F_0F0F);
        send_beat(OP_LOOKUP, 32'sd8, '0, '0);
        send_beat(OP_LOOKUP, -32'sd16, '0, '0);
        send_beat(OP_LOOKUP, 32'h8000_0001, '0, '0);
        send_beat(OP_LOOKUP, 32'sd24, '0, '0);
        send_beat(OP_WRITE, '0, 10'd0, 32'hDEAD_BEEF);
        send_beat(OP_READ, '0, 10'd0, '0);
        send_beat(OP_READ, '0, 10'd7, '0);
        send_beat(OP_READ, '0, 10'd8, '0);
        send_beat(OP_WRITE, '0, 10'h3FF, 32'h1);
        for (int n = 0; n < 6; n++)
            send_beat(OP_INSERT, 32'(n * 8 + 3), '0, $urandom());
    endtask

    task automatic test_degenerate_sizes();
        set_table_size(11'd0);
        send_beat(OP_INSERT, 32'sd77, '0, 32'h77);
        send_beat(OP_INSERT, 32'sd78, '0, 32'h78);
        send_beat(OP_LOOKUP, 32'sd77, '0, '0);
        send_beat(OP_READ, '0, 10'd1, '0);
        set_table_size(11'd1);
        send_beat(OP_READ, '0, 10'd0, '0);
    endtask

    task automatic test_random_ops(int count, logic [CW-1:0] size, int key_span);
        logic [KW-1:0] used_keys[$];
        logic [KW-1:0] k;
        int unsigned s;
        set_table_size(size);
        s = (size == 0) ? 1 : (size > DEPTH ? DEPTH : size);
        for (int n = 0; n < count; n++) begin
            idle_out = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    k = (key_span != 0) ? 32'($urandom_range(0, key_span)) : random_key();
                    if ($urandom_range(0, 1)) k = -k;
                    if ($urandom_range(0, 15) == 0) k = $urandom_range(0, 1) ? 32'h7FFF_FFFF
                                                                        : 32'h8000_0001;
                    used_keys.push_back(k);
                    send_beat(OP_INSERT, k, AW'($urandom()), $urandom());
                end
                4, 5, 6: begin
                    if (used_keys.size() != 0 && $urandom_range(0, 3) != 0)
                        k = used_keys[$urandom_range(0, used_keys.size() - 1)];
                    else
                        k = random_key();
                    send_beat(OP_LOOKUP, k, AW'($urandom()), $urandom(),
                              $urandom_range(0, 2) != 0);
                end
                default: begin
                    int unsigned idx;
                    idx = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1023)
                                                    : $urandom_range(0, s - 1);
                    // never read a slot whose key was never stored
                    if (idx < s && !tbl_used[idx] && $urandom_range(0, 1))
                        send_beat(OP_WRITE, random_key(), idx[AW-1:0], $urandom());
                    else if (idx < s && tbl_used[idx])
                        send_beat(OP_READ, random_key(), idx[AW-1:0], $urandom());
                    else
                        send_beat(OP_WRITE, random_key(), idx[AW-1:0], $urandom());
                end
            endcase
        end
        idle_out = 1'b1;
    endtask

    initial begin
        for (int n = 0; n < DEPTH; n++) begin
            tbl_key[n] = '0;
            tbl_used[n] = 1'b0;
            tbl_probes[n] = '0;
            tbl_data[n] = '0;
        end
        tbl_fill = 0;
        tbl_size = DEPTH;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_random_ops(25, 11'd1024, 0);
        test_small_table_edges();
        test_degenerate_sizes();
        test_random_ops(80, 11'd37, 200);
        test_random_ops(60, 11'd5, 40);
        test_random_ops(80, 11'd2047, 0);
        test_random_ops(90, 11'd64, 300);
        test_random_ops(60, 11'd13, 0);
        drain_results();
        idle_cycles(50);
        $display("covered %0d beats, %0d results, sizes 0 to 2047, fill %0d", beat_count,
                 result_count, tbl_fill);
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("timeout with %0d results pending", pending_results.size());
        $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/hqp_pkg.sv
rtl/hqp_ram.sv
rtl/hqp_mod.sv
rtl/hash_table_quadratic_probe_unit.sv
tb/hash_table_quadratic_probe_unit_tb.sv
